// File: hw/rtl/keyed_record_table_upsert_assert.svh
// Assertion macros shared by the keyed record table RTL.
`ifndef KEYED_RECORD_TABLE_UPSERT_ASSERT_SVH
`define KEYED_RECORD_TABLE_UPSERT_ASSERT_SVH
`ifndef SYNTHESIS
`define KRTU_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("keyed record table assertion failed");
`define KRTU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("keyed record table assertion failed");
`else
`define KRTU_ASSERT_SAME(lbl, pre, post)
`define KRTU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/krtu_pkg.sv
// Package with sizes, codes and shared types of the keyed record table.
`default_nettype none
package krtu_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 16;
    localparam int VAL_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int REC_W    = 2 * VAL_W;

    typedef enum logic [1:0] {
        STATUS_HIT      = 2'd0,
        STATUS_INSERTED = 2'd1,
        STATUS_MISS     = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0] place;
        logic [VAL_W-1:0] element;
    } record_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             key_we;
        logic             data_we;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0] key_wdata;
        record_t          data_wdata;
    } ram_req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  element;
        logic [VAL_W-1:0]  place;
    } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/krtu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module krtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/krtu_ctrl.sv
// Sequencer that walks the key memory, then updates, appends or reports the outcome.
`default_nettype none
`include "keyed_record_table_upsert_assert.svh"
module krtu_ctrl
    import krtu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_mode,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire logic [VAL_W-1:0] in_element,
    input  wire logic [VAL_W-1:0] in_place,
    input  wire logic [KEY_W-1:0] key_rdata,
    input  wire record_t          data_rdata,
    output ram_req_t              ram_req,
    output logic                  res_valid,
    output result_t               res,
    input  wire logic             res_take
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             mode_reg, mode_next;
    logic [KEY_W-1:0] key_reg, key_next;
    record_t          rec_reg, rec_next;
    result_t          res_reg, res_next;
    logic             hit;
    logic             last;
    logic             full;

    assign hit  = (used_reg != '0) && (key_rdata == key_reg);
    assign last = (CNT_W'(idx_reg) + CNT_W'(1)) >= used_reg;
    assign full = used_reg == CNT_W'(CAPACITY);

    assign in_ready  = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_HOLD;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        rec_next   = rec_reg;
        res_next   = res_reg;

        ram_req.rd_addr    = '0;
        ram_req.key_we     = 1'b0;
        ram_req.data_we    = 1'b0;
        ram_req.wr_addr    = idx_reg;
        ram_req.key_wdata  = key_reg;
        ram_req.data_wdata = rec_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next           = in_mode;
                    key_next            = in_key;
                    rec_next.element    = in_element;
                    rec_next.place      = in_place;
                    idx_next            = '0;
                    state_next          = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_req.rd_addr = IDX_W'(idx_reg + IDX_W'(1));
                if (hit)
                begin
                    res_next.status = STATUS_HIT;
                    res_next.slot   = SLOT_W'(idx_reg);
                    if (mode_reg)
                    begin
                        ram_req.data_we  = 1'b1;
                        res_next.element = rec_reg.element;
                        res_next.place   = rec_reg.place;
                    end
                    else
                    begin
                        res_next.element = data_rdata.element;
                        res_next.place   = data_rdata.place;
                    end
                    state_next = ST_HOLD;
                end
                else if (last)
                begin
                    res_next.slot    = '0;
                    res_next.element = '0;
                    res_next.place   = '0;
                    if (!mode_reg)
                    begin
                        res_next.status = STATUS_MISS;
                    end
                    else if (full)
                    begin
                        res_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        ram_req.key_we   = 1'b1;
                        ram_req.data_we  = 1'b1;
                        ram_req.wr_addr  = used_reg[IDX_W-1:0];
                        used_next        = CNT_W'(used_reg + CNT_W'(1));
                        res_next.status  = STATUS_INSERTED;
                        res_next.slot    = SLOT_W'(used_reg[IDX_W-1:0]);
                        res_next.element = rec_reg.element;
                        res_next.place   = rec_reg.place;
                    end
                    state_next = ST_HOLD;
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + IDX_W'(1));
                end
            end
            ST_HOLD:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        mode_reg <= mode_next;
        key_reg  <= key_next;
        rec_reg  <= rec_next;
        res_reg  <= res_next;
    end

    `KRTU_ASSERT_SAME(a_used_bounded, 1'b1, used_reg <= CNT_W'(CAPACITY))
    `KRTU_ASSERT_NEXT(a_append_counts, ram_req.key_we,
                      used_reg == CNT_W'($past(used_reg) + CNT_W'(1)))
    `KRTU_ASSERT_SAME(a_write_in_scan, ram_req.data_we,
                      (state_reg == ST_SCAN) && mode_reg)
    `KRTU_ASSERT_SAME(a_key_write_on_miss, ram_req.key_we, !hit && last && !full)
endmodule
`default_nettype wire

// File: hw/rtl/keyed_record_table_upsert.sv
// Top level of the keyed record table: stream ports, record memories and result register.
//
// The slave stream takes one request per transaction: s_tuser selects lookup (0)
// or register (1), s_tdata carries the key, element id and world index.
// Each request produces exactly one response transaction on the master stream,
// with the status code in m_tuser and slot, element id and world index in m_tdata.
// Requests are processed one at a time. After acceptance the key memory is
// walked one entry per cycle from slot 0; the walk ends at the first matching
// key or at the last used entry, reading through the single read port of the
// key memory. The response then moves from the result register of the
// sequencer into the output register once that register is free or being read
// out. A new request is accepted while a response still waits in the output
// register. If the receiver stalls, the next response is held inside and no
// further request is taken until the output register frees up.
// Reset empties the table at once by clearing the used count; no clearing pass
// over the memories is needed.
`default_nettype none
`include "keyed_record_table_upsert_assert.svh"
module keyed_record_table_upsert
    import krtu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // key, element_in, place_in
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // slot, element_out, place_out, zero fill
    output logic      [1:0]  m_tuser    // status
);
    ram_req_t         ram_req;
    logic [KEY_W-1:0] key_rdata;
    record_t          data_rdata;
    logic             res_valid;
    result_t          res;
    logic             res_take;
    logic             m_tvalid_reg;
    result_t          m_res_reg;

    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    krtu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_key     (s_tdata[15:0]),
        .in_element (s_tdata[31:16]),
        .in_place   (s_tdata[47:32]),
        .key_rdata  (key_rdata),
        .data_rdata (data_rdata),
        .ram_req    (ram_req),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    krtu_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_req.key_we),
        .waddr (ram_req.wr_addr),
        .wdata (ram_req.key_wdata),
        .raddr (ram_req.rd_addr),
        .rdata (key_rdata)
    );

    krtu_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_req.data_we),
        .waddr (ram_req.wr_addr),
        .wdata (ram_req.data_wdata),
        .raddr (ram_req.rd_addr),
        .rdata (data_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {2'b00, m_res_reg.place, m_res_reg.element, m_res_reg.slot};

    `KRTU_ASSERT_NEXT(a_take_fills_output, res_take, m_tvalid_reg)
    `KRTU_ASSERT_SAME(a_no_accept_while_busy, res_valid, !s_tready)
endmodule
`default_nettype wire

// File: tb/tb_keyed_record_table_upsert.sv
// Self-checking testbench for the keyed record table with lookup and upsert requests.
`timescale 1ns / 1ps
module tb_keyed_record_table_upsert;
    import krtu_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 80;

    class table_scoreboard;
        logic [KEY_W-1:0] keys[CAPACITY];
        record_t          records[CAPACITY];
        int               used;
        result_t          expected_q[$];
        int               errors;
        int               responses;

        function new();
            used      = 0;
            errors    = 0;
            responses = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(bit reg_mode, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] element, logic [VAL_W-1:0] place);
            result_t r;
            int      hit_idx;
            hit_idx   = -1;
            r.status  = STATUS_MISS;
            r.slot    = '0;
            r.element = '0;
            r.place   = '0;
            for (int i = 0; i < used; i++) begin
                if (keys[i] == key) begin
                    hit_idx = i;
                    break;
                end
            end
            if (hit_idx >= 0) begin
                if (reg_mode) begin
                    records[hit_idx].element = element;
                    records[hit_idx].place   = place;
                end
                r.status  = STATUS_HIT;
                r.slot    = hit_idx[SLOT_W-1:0];
                r.element = records[hit_idx].element;
                r.place   = records[hit_idx].place;
            end else if (reg_mode && used >= CAPACITY) begin
                r.status = STATUS_FULL;
            end else if (reg_mode) begin
                keys[used]            = key;
                records[used].element = element;
                records[used].place   = place;
                r.status  = STATUS_INSERTED;
                r.slot    = used[SLOT_W-1:0];
                r.element = element;
                r.place   = place;
                used++;
            end
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("response %0d: %s mismatch, got %0h, expected %0h",
                     responses, what, got, want);
            errors++;
        endtask

        task check_response(logic [1:0] status, logic [39:0] data);
            result_t want;
            responses++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected response status", status, 0);
            end else begin
                want = expected_q.pop_front();
                if (status != want.status)
                    report_mismatch("status", status, want.status);
                if (data[5:0] != want.slot)
                    report_mismatch("slot", data[5:0], want.slot);
                if (data[21:6] != want.element)
                    report_mismatch("element", data[21:6], want.element);
                if (data[37:22] != want.place)
                    report_mismatch("place", data[37:22], want.place);
                if (data[39:38] != 2'b00)
                    report_mismatch("fill bits", data[39:38], 0);
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    table_scoreboard sb;
    bit              hold_off_req = 1'b0;
    int              idle_cycles  = 0;

    keyed_record_table_upsert DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_response(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int stretch;
        int style;
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                style   = $urandom_range(0, 2);
                stretch = $urandom_range(10, 120);
                repeat (stretch)
                begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_request(input bit reg_mode, input logic [15:0] key,
                                input logic [15:0] element, input logic [15:0] place);
        s_tvalid <= 1'b1;
        s_tuser  <= reg_mode;
        s_tdata  <= {place, element, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_random_request();
        bit          reg_mode;
        logic [15:0] key;
        reg_mode = 1'($urandom_range(0, 1));
        if (sb.used == 0 || $urandom_range(0, 9) < 4)
            key = 16'($urandom);
        else
            key = sb.keys[$urandom_range(0, sb.used - 1)];
        send_request(reg_mode, key, 16'($urandom), 16'($urandom));
    endtask

    task automatic run_random(input int count, input int hold_at);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                if (sent == hold_at)
                    hold_off_req = 1'b1;
                send_random_request();
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookups on the empty table, inserts at the key extremes, then hits, updates, more inserts and misses.
        send_request(1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_request(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
        send_request(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_request(1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_request(1'b0, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(1'b1, 16'h0000, 16'h1234, 16'hABCD);
        send_request(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(1'b0, 16'h5555, 16'hFFFF, 16'hFFFF);
        send_request(1'b1, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_request(1'b1, 16'h5555, 16'hAAAA, 16'h5555);
        send_request(1'b0, 16'hAAAA, 16'h0000, 16'h0000);
        send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(1'b0, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(1'b0, 16'h0001, 16'h0000, 16'h0000);
        wait_for_drain();

        run_random(400, 150);
        wait_for_drain();
        run_random(400, -1);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/krtu_pkg.sv
hw/rtl/krtu_ram.sv
hw/rtl/krtu_ctrl.sv
hw/rtl/keyed_record_table_upsert.sv
tb/tb_keyed_record_table_upsert.sv
